// File: sv/frsqrt_pkg.sv
// Shared types and constants for the inverse square root Newton unit.
package frsqrt_pkg;

  localparam logic [31:0] MAGIC_RESET = 32'h5F37642F;
  localparam logic [31:0] TOL_RESET   = 32'h3C4CCCCD;
  localparam logic [6:0]  LIMIT_RESET = 7'd110;

  localparam logic [1:0] REG_MAGIC = 2'd0;
  localparam logic [1:0] REG_TOL   = 2'd1;
  localparam logic [1:0] REG_LIMIT = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_SQRT, ST_SROUND, ST_DIV, ST_DROUND, ST_LOOP,
    ST_HALF, ST_SQ1, ST_SQ2, ST_SUB, ST_MULY, ST_DIFF, ST_CHK, ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    FOP_NONE, FOP_HALF, FOP_SQ1, FOP_SQ2, FOP_SUB, FOP_MULY, FOP_DIFF
  } fop_t;

  typedef struct packed {
    logic load;
    logic sqrt_init;
    logic sqrt_step;
    logic div_init;
    logic div_step;
    logic ref_round;
    fop_t op;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic ref_special;
    logic iter_last;
    logic more;
    logic conv;
    logic out_busy;
  } dp_stat_t;

endpackage

// File: sv/frsqrt_ctrl.sv
// Sequencer: reference root and division, then the Newton step loop.
module frsqrt_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  frsqrt_pkg::dp_stat_t stat,
  output frsqrt_pkg::dp_cmd_t  cmd
);
  import frsqrt_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_PREP;
      ST_PREP:   state_next = stat.ref_special ? ST_LOOP : ST_SQRT;
      ST_SQRT:   if (stat.iter_last) state_next = ST_SROUND;
      ST_SROUND: state_next = ST_DIV;
      ST_DIV:    if (stat.iter_last) state_next = ST_DROUND;
      ST_DROUND: state_next = ST_LOOP;
      ST_LOOP:   state_next = stat.more ? ST_HALF : ST_DONE;
      ST_HALF:   state_next = ST_SQ1;
      ST_SQ1:    state_next = ST_SQ2;
      ST_SQ2:    state_next = ST_SUB;
      ST_SUB:    state_next = ST_MULY;
      ST_MULY:   state_next = ST_DIFF;
      ST_DIFF:   state_next = ST_CHK;
      ST_CHK:    state_next = (stat.conv || !stat.more) ? ST_DONE : ST_HALF;
      ST_DONE:   if (!stat.out_busy) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.op   = FOP_NONE;
    s_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_PREP:   cmd.sqrt_init = !stat.ref_special;
      ST_SQRT:   cmd.sqrt_step = 1'b1;
      ST_SROUND: cmd.div_init  = 1'b1;
      ST_DIV:    cmd.div_step  = 1'b1;
      ST_DROUND: cmd.ref_round = 1'b1;
      ST_HALF:   cmd.op = FOP_HALF;
      ST_SQ1:    cmd.op = FOP_SQ1;
      ST_SQ2:    cmd.op = FOP_SQ2;
      ST_SUB:    cmd.op = FOP_SUB;
      ST_MULY:   cmd.op = FOP_MULY;
      ST_DIFF:   cmd.op = FOP_DIFF;
      ST_DONE:   cmd.out_load = !stat.out_busy;
      default:   cmd = '0;
    endcase
  end

endmodule

// File: sv/frsqrt_dp.sv
// Datapath: config registers, serial root and divider, float mul/add, output register.
module frsqrt_dp #(
  parameter int STEP_LIMIT_MAX = 127
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic [31:0]         operand_bits,
  input  frsqrt_pkg::dp_cmd_t cmd,
  output frsqrt_pkg::dp_stat_t stat,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [39:0]         out_data
);
  import frsqrt_pkg::*;

  localparam logic [31:0] CANON_NAN = 32'h7FC00000;
  localparam logic [31:0] F_HALF    = 32'h3F000000;
  localparam logic [31:0] F_THREEH  = 32'h3FC00000;

  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    n = 6'd48;
    for (int i = 0; i < 48; i++) if (v[i]) n = 6'(47 - i);
    return n;
  endfunction

  // m normalised with m[26] set (or smaller for tiny values); value m * 2^(e-26)
  function automatic logic [31:0] round_pack(input logic sgn, input logic signed [11:0] e,
                                             input logic [26:0] m);
    logic signed [12:0] be;
    logic [5:0]  sh;
    logic [8:0]  ee;
    logic [26:0] mm;
    logic        lost, g, s, rnd;
    logic [24:0] r;
    logic [22:0] frac;
    be = 13'(e) + 13'sd127;
    if (be >= 13'sd1) begin
      sh = 6'd0;
      ee = be[8:0];
    end else begin
      ee = 9'd0;
      if (be < -13'sd26) sh = 6'd27;
      else sh = 6'(13'sd1 - be);
    end
    mm   = m >> sh;
    lost = (mm << sh) != m;
    g    = mm[2];
    s    = mm[1] | mm[0] | lost;
    rnd  = g & (s | mm[3]);
    r    = {1'b0, mm[26:3]} + 25'(rnd);
    if (m == '0) return {sgn, 31'b0};
    if (ee == 9'd0) return {sgn, 7'b0, r[23], r[22:0]};
    if (r[24]) begin
      ee   = ee + 9'd1;
      frac = r[23:1];
    end else begin
      frac = r[22:0];
    end
    if (ee >= 9'd255) return {sgn, 8'hFF, 23'b0};
    return {sgn, ee[7:0], frac};
  endfunction

  function automatic logic is_nan(input logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != '0);
  endfunction

  function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
    logic sgn, ia, ib, za, zb;
    logic [23:0] sa, sb;
    logic signed [11:0] ea, eb;
    logic [47:0] p, pn;
    logic [5:0]  lz;
    sgn = a[31] ^ b[31];
    ia  = a[30:0] == 31'h7F800000;
    ib  = b[30:0] == 31'h7F800000;
    za  = a[30:0] == '0;
    zb  = b[30:0] == '0;
    sa  = {a[30:23] != '0, a[22:0]};
    sb  = {b[30:23] != '0, b[22:0]};
    ea  = (a[30:23] == '0) ? -12'sd126 : 12'(a[30:23]) - 12'sd127;
    eb  = (b[30:23] == '0) ? -12'sd126 : 12'(b[30:23]) - 12'sd127;
    p   = 48'(sa) * 48'(sb);
    lz  = lzc48(p);
    pn  = p << lz;
    if (is_nan(a) || is_nan(b) || (ia && zb) || (za && ib)) return CANON_NAN;
    if (ia || ib) return {sgn, 8'hFF, 23'b0};
    if (za || zb) return {sgn, 31'b0};
    return round_pack(sgn, ea + eb + 12'sd1 - 12'(lz),
                      {pn[47:22], pn[21] | (|pn[20:0])});
  endfunction

  function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] x, y;
    logic [23:0] sx, sy;
    logic signed [11:0] ex, ey;
    logic [8:0]  d;
    logic [26:0] xm, ym0, ym;
    logic [27:0] sum;
    logic [5:0]  lz;
    logic [26:0] m;
    logic signed [11:0] e;
    if (a[30:0] < b[30:0]) begin
      x = b;
      y = a;
    end else begin
      x = a;
      y = b;
    end
    sx  = {x[30:23] != '0, x[22:0]};
    sy  = {y[30:23] != '0, y[22:0]};
    ex  = (x[30:23] == '0) ? -12'sd126 : 12'(x[30:23]) - 12'sd127;
    ey  = (y[30:23] == '0) ? -12'sd126 : 12'(y[30:23]) - 12'sd127;
    d   = 9'(ex - ey);
    xm  = {sx, 3'b0};
    ym0 = {sy, 3'b0};
    if (d >= 9'd27) ym = {26'b0, |ym0};
    else ym = (ym0 >> d) | {26'b0, ((ym0 >> d) << d) != ym0};
    if (x[31] == y[31]) sum = {1'b0, xm} + {1'b0, ym};
    else sum = {1'b0, xm} - {1'b0, ym};
    lz = lzc48({sum[26:0], 21'b0});
    if (sum[27]) begin
      m = {sum[27:2], sum[1] | sum[0]};
      e = ex + 12'sd1;
    end else begin
      m = sum[26:0] << lz;
      e = ex - 12'(lz);
    end
    if (is_nan(a) || is_nan(b)) return CANON_NAN;
    if (a[30:0] == 31'h7F800000 && b[30:0] == 31'h7F800000 && a[31] != b[31])
      return CANON_NAN;
    if (a[30:0] == 31'h7F800000) return a;
    if (b[30:0] == 31'h7F800000) return b;
    if (a[30:0] == '0 && b[30:0] == '0) return {a[31] & b[31], 31'b0};
    if (a[30:0] == '0) return b;
    if (b[30:0] == '0) return a;
    if (sum == '0) return 32'b0;
    return round_pack(x[31], e, m);
  endfunction

  // configuration
  logic [31:0] magic, tol;
  logic [6:0]  step_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      magic      <= MAGIC_RESET;
      tol        <= TOL_RESET;
      step_limit <= LIMIT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAGIC: magic      <= cfg_data;
        REG_TOL:   tol        <= cfg_data;
        REG_LIMIT: step_limit <= cfg_data[6:0];
        default:   ;
      endcase
    end
  end

  // item state
  logic [31:0] x, y, h, t, d, ref_bits, first;
  logic [6:0]  limit, count;
  logic        ref_special;
  logic [47:0] rad;
  logic [25:0] rem;
  logic [23:0] root;
  logic signed [9:0] sexp;
  logic [23:0] dsig, rmd;
  logic signed [9:0] des;
  logic [26:0] q;
  logic [4:0]  iter;

  // special references, decided straight from the operand
  logic        in_special;
  logic [31:0] in_ref;
  always_comb begin
    in_special = 1'b1;
    in_ref     = CANON_NAN;
    if (operand_bits[30:0] > 31'h7F800000) in_ref = CANON_NAN;
    else if (operand_bits[30:0] == '0) in_ref = {operand_bits[31], 8'hFF, 23'b0};
    else if (operand_bits[31]) in_ref = CANON_NAN;
    else if (operand_bits[30:0] == 31'h7F800000) in_ref = 32'b0;
    else in_special = 1'b0;
  end

  // root set-up: normalise the significand, make the exponent even
  logic [23:0] sm;
  logic signed [9:0] se0, se1;
  logic [47:0] big;
  logic [5:0]  slz;
  always_comb begin
    slz = lzc48({1'b0, x[22:0], 24'b0});
    if (x[30:23] == '0) begin
      sm  = 24'({1'b0, x[22:0]} << slz);
      se0 = -10'sd149 - 10'(slz);
    end else begin
      sm  = {1'b1, x[22:0]};
      se0 = 10'(x[30:23]) - 10'sd150;
    end
    if (se0[0]) begin
      big = 48'(sm) << 23;
      se1 = se0 - 10'sd23;
    end else begin
      big = 48'(sm) << 24;
      se1 = se0 - 10'sd24;
    end
  end

  logic [27:0] s_t, s_trial;
  logic [24:0] rr, r2;
  assign s_t     = {rem, rad[47:46]};
  assign s_trial = {2'b0, root, 2'b01};
  assign rr      = {1'b0, root} + 25'(rem > {2'b0, root});
  assign r2      = {rmd, 1'b0};

  logic [31:0] fres;
  always_comb begin
    case (cmd.op)
      FOP_HALF: fres = fmul(x, F_HALF);
      FOP_SQ1:  fres = fmul(h, y);
      FOP_SQ2:  fres = fmul(t, y);
      FOP_SUB:  fres = fadd(F_THREEH, {~t[31], t[30:0]});
      FOP_MULY: fres = fmul(y, t);
      FOP_DIFF: fres = fadd(ref_bits, {~y[31], y[30:0]});
      default:  fres = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x           <= operand_bits;
      y           <= magic - {1'b0, operand_bits[31:1]};
      count       <= '0;
      first       <= '0;
      ref_special <= in_special;
      ref_bits    <= in_ref;
      if (32'(step_limit) > 32'(STEP_LIMIT_MAX)) limit <= 7'(STEP_LIMIT_MAX);
      else limit <= step_limit;
    end
    if (cmd.sqrt_init) begin
      rad  <= big;
      rem  <= '0;
      root <= '0;
      sexp <= se1;
      iter <= 5'd23;
    end
    if (cmd.sqrt_step) begin
      rad  <= rad << 2;
      iter <= iter - 5'd1;
      if (s_t >= s_trial) begin
        rem  <= 26'(s_t - s_trial);
        root <= {root[22:0], 1'b1};
      end else begin
        rem  <= s_t[25:0];
        root <= {root[22:0], 1'b0};
      end
    end
    if (cmd.div_init) begin
      if (rr[24]) begin
        dsig <= rr[24:1];
        des  <= (sexp >>> 1) + 10'sd24;
      end else begin
        dsig <= rr[23:0];
        des  <= (sexp >>> 1) + 10'sd23;
      end
      rmd  <= 24'h800000;
      q    <= '0;
      iter <= 5'd26;
    end
    if (cmd.div_step) begin
      iter <= iter - 5'd1;
      if (r2 >= {1'b0, dsig}) begin
        rmd <= 24'(r2 - {1'b0, dsig});
        q   <= {q[25:0], 1'b1};
      end else begin
        rmd <= r2[23:0];
        q   <= {q[25:0], 1'b0};
      end
    end
    if (cmd.ref_round) begin
      // quotient of exactly one when the root significand is a power of two
      if (dsig == 24'h800000) ref_bits <= round_pack(1'b0, -12'(des), 27'h4000000);
      else ref_bits <= round_pack(1'b0, -12'(des) - 12'sd1, {q[26:1], q[0] | (rmd != '0)});
    end
    case (cmd.op)
      FOP_HALF: h <= fres;
      FOP_SQ1, FOP_SQ2, FOP_SUB: t <= fres;
      FOP_MULY: begin
        y     <= fres;
        count <= count + 7'd1;
        if (count == '0) first <= is_nan(fres) ? CANON_NAN : fres;
      end
      FOP_DIFF: d <= {1'b0, fres[30:0]};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_data <= {1'b0, first, count};
  end

  assign stat.ref_special = ref_special;
  assign stat.iter_last   = iter == '0;
  assign stat.more        = count < limit;
  assign stat.conv        = !is_nan(d) && !is_nan(tol) && !tol[31] && (d[30:0] < tol[30:0]);
  assign stat.out_busy    = out_valid && !out_ready;

endmodule

// File: sv/fast_rsqrt_newton_convergence_unit.sv
// Top level of the inverse square root Newton unit.
//
//  channel  direction  handshake                    payload
//  s_*      in         s_tvalid / s_tready          operand_bits
//  m_*      out        m_tvalid / m_tready          steps_done, first_step_bits
//  cfg_*    in         cfg_valid / cfg_ready        cfg_index, cfg_data
//
// An item first forms the reference from 24 root iterations and 27 divider
// iterations (skipped for zero, inf, NaN and negative inputs), then runs each
// Newton step through the shared mul/add and checks it against the reference.
// Reset is synchronous; config registers return to their documented defaults.
// A waiting result sits in the output register; the next item is taken meanwhile
// and only holds in its final state if the previous result is still untaken.
module fast_rsqrt_newton_convergence_unit #(
  parameter int STEP_LIMIT_MAX = 127
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] operand_bits
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [6:0] steps_done, [38:7] first_step_bits, [39] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import frsqrt_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  frsqrt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  frsqrt_dp #(
    .STEP_LIMIT_MAX (STEP_LIMIT_MAX)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .operand_bits (s_tdata),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_data     (m_tdata)
  );

endmodule

// File: sim/tb_fast_rsqrt_newton_convergence_unit.sv
// Testbench for the inverse square root Newton unit: bit-exact float predictor and scoreboard.
module tb_fast_rsqrt_newton_convergence_unit;
  import frsqrt_pkg::*;

  localparam int LIMIT_CAP     = 127;
  localparam int IDLE_LIMIT    = 30000;
  localparam logic [31:0] QNAN = 32'h7FC00000;

  typedef struct packed {
    logic [6:0]  steps_done;
    logic [31:0] first_step_bits;
  } rsqrt_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_MAGIC;
  logic [31:0] cfg_data = '0;

  fast_rsqrt_newton_convergence_unit #(.STEP_LIMIT_MAX(LIMIT_CAP)) DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow registers, updated on each config transfer
  logic [31:0] sh_magic = MAGIC_RESET;
  logic [31:0] sh_tol   = TOL_RESET;
  logic [6:0]  sh_limit = LIMIT_RESET;

  logic [31:0] operand_q[$];
  rsqrt_res_t  expected_q[$];
  int          mismatches = 0;
  int          ops_sent = 0, results_seen = 0, limit_runs = 0, cfg_writes = 0;
  int          idle_cycles = 0;
  bit          s_took = 0, cfg_took = 0;

  // single bits -> real (exact)
  function automatic real sgl_to_real(input logic [31:0] b);
    logic [63:0] d;
    logic [22:0] f;
    int          e;
    f = b[22:0];
    e = b[30:23];
    d = '0;
    d[63] = b[31];
    if (e == 255) begin
      d[62:52] = 11'h7FF;
      d[51:29] = f;
    end else if (e == 0 && f == 0) begin
      d[62:0] = '0;
    end else begin
      if (e == 0) begin
        // f[22] weighs 2^-127 once normalised
        e = 0;
        while (!f[22]) begin
          f = f << 1;
          e--;
        end
        f = f << 1;   // drop the leading one
      end
      d[62:52] = 11'(e - 127 + 1023);
      d[51:29] = f;
    end
    return $bitstoreal(d);
  endfunction

  // real -> single bits, round to nearest even; double then single rounding is
  // innocuous for + - * / sqrt since 53 >= 2*24+2
  function automatic logic [31:0] real_to_sgl(input real r);
    logic [63:0] d, sig, kept, rem, half;
    int          ue, sh;
    logic        sgn;
    d = $realtobits(r);
    sgn = d[63];
    if (d[62:52] == 11'h7FF)
      return (d[51:0] != 0) ? QNAN : {sgn, 8'hFF, 23'd0};
    if (d[62:52] == 0)
      return {sgn, 31'd0};
    ue = int'(d[62:52]) - 1023;
    sig = {11'd0, 1'b1, d[51:0]};
    sh = (ue >= -126) ? 29 : 29 + (-126 - ue);
    if (sh > 60) return {sgn, 31'd0};
    kept = sig >> sh;
    rem  = sig & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && kept[0])) kept++;
    if (ue < -126) return {sgn, kept[30:0]};
    if (kept == (64'd1 << 24)) begin
      kept = kept >> 1;
      ue++;
    end
    if (ue > 127) return {sgn, 8'hFF, 23'd0};
    return {sgn, 8'(ue + 127), kept[22:0]};
  endfunction

  function automatic bit is_nan(input logic [31:0] b);
    return b[30:23] == 8'hFF && b[22:0] != 0;
  endfunction

  function automatic logic [31:0] inv_root_bits(input logic [31:0] xb);
    logic [31:0] rt;
    if (is_nan(xb)) return QNAN;
    if (xb[30:0] == 0) return {xb[31], 8'hFF, 23'd0};
    if (xb[31]) return QNAN;
    if (xb[30:0] == 31'h7F800000) return 32'd0;
    rt = real_to_sgl($sqrt(sgl_to_real(xb)));
    return real_to_sgl(1.0 / sgl_to_real(rt));
  endfunction

  function automatic rsqrt_res_t newton_predict(input logic [31:0] xb);
    rsqrt_res_t  res;
    logic [31:0] y, h, t, target, dbits;
    int          lim, cnt;
    y      = sh_magic - (xb >> 1);
    target = inv_root_bits(xb);
    lim    = (sh_limit > LIMIT_CAP) ? LIMIT_CAP : sh_limit;
    cnt    = 0;
    res    = '0;
    while (cnt < lim) begin
      h = real_to_sgl(sgl_to_real(xb) * 0.5);
      t = real_to_sgl(sgl_to_real(h) * sgl_to_real(y));
      t = real_to_sgl(sgl_to_real(t) * sgl_to_real(y));
      t = real_to_sgl(1.5 - sgl_to_real(t));
      y = real_to_sgl(sgl_to_real(y) * sgl_to_real(t));
      cnt++;
      if (cnt == 1) res.first_step_bits = is_nan(y) ? QNAN : y;
      if (is_nan(target) || is_nan(y)) continue;
      dbits = real_to_sgl(sgl_to_real(target) - sgl_to_real(y));
      dbits[31] = 1'b0;
      if (!is_nan(dbits) && !is_nan(sh_tol) && sgl_to_real(dbits) < sgl_to_real(sh_tol))
        break;
    end
    res.steps_done = 7'(cnt);
    return res;
  endfunction

  // scoreboard: sample at the rising edge
  always @(posedge clk) begin
    rsqrt_res_t got, want;
    if (!rst) begin
      idle_cycles++;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MAGIC: sh_magic = cfg_data;
          REG_TOL:   sh_tol   = cfg_data;
          REG_LIMIT: sh_limit = cfg_data[6:0];
          default: ;
        endcase
        cfg_took = 1;
        cfg_writes++;
        idle_cycles = 0;
      end
      if (s_tvalid && s_tready) begin
        want = newton_predict(s_tdata);
        if (want.steps_done == sh_limit && sh_limit != 0) limit_runs++;
        expected_q.push_back(want);
        s_took = 1;
        ops_sent++;
        idle_cycles = 0;
      end
      if (m_tvalid && m_tready) begin
        got = {m_tdata[6:0], m_tdata[38:7]};
        results_seen++;
        idle_cycles = 0;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", m_tdata);
        end else begin
          want = expected_q.pop_front();
          if (got.steps_done != want.steps_done ||
              got.first_step_bits != want.first_step_bits) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: steps exp %0d got %0d, first exp %h got %h",
                       results_seen, want.steps_done, got.steps_done,
                       want.first_step_bits, got.first_step_bits);
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // operand driver: bursts with random gaps, changes on the falling edge
  int burst_left = 1, gap_left = 0;
  always @(negedge clk) begin
    if (!rst && (!s_tvalid || s_took)) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (operand_q.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tdata  <= operand_q.pop_front();
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 6);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    s_took = 0;
  end

  // result receiver: rotating stall pattern, reloaded now and then
  logic [15:0] rdy_pat = 16'hFFFF;
  always @(negedge clk) begin
    if (!rst) begin
      if ($urandom_range(0, 63) == 0)
        case ($urandom_range(0, 3))
          0: rdy_pat = 16'hFFFF;
          1: rdy_pat = 16'h0000;
          default: rdy_pat = 16'($urandom);
        endcase
      rdy_pat = {rdy_pat[0], rdy_pat[15:1]};
      m_tready <= rdy_pat[0];
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_took);
    cfg_took = 0;
    cfg_valid <= 1'b0;
  endtask

  task automatic drain;
    while (operand_q.size() != 0 || s_tvalid || expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_operand;
    if ($urandom_range(0, 9) < 6)
      return {1'b0, 8'($urandom_range(1, 254)), 23'($urandom)};
    return $urandom;
  endfunction

  task automatic run_phase(input logic [31:0] magic, input logic [31:0] tol,
                           input logic [6:0] lim, input int count);
    drain();
    write_reg(REG_MAGIC, magic);
    write_reg(REG_TOL, tol);
    write_reg(REG_LIMIT, lim);
    repeat (count) operand_q.push_back(rand_operand());
  endtask

  initial begin
    logic [31:0] corner[$];
    corner = '{32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000, 32'h7FC00000,
               32'hFFFFFFFF, 32'h7F800001, 32'h00000001, 32'h007FFFFF, 32'h00800000,
               32'h7F7FFFFF, 32'h3F800000, 32'h40800000, 32'h3E800000, 32'hBF800000,
               32'h3F000000, 32'h4B000000, 32'h1E3CE508, 32'h5F37642F, 32'hFFFFFFFE};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // reset defaults, corner operands first
    foreach (corner[i]) operand_q.push_back(corner[i]);
    repeat (80) operand_q.push_back(rand_operand());
    run_phase(MAGIC_RESET, TOL_RESET, 7'd0, 30);
    foreach (corner[i]) operand_q.push_back(corner[i]);
    run_phase(MAGIC_RESET, 32'h00000000, 7'd127, 25);
    run_phase(MAGIC_RESET, 32'hFFFFFFFF, 7'd5, 30);
    run_phase(MAGIC_RESET, 32'h7F7FFFFF, 7'd1, 30);
    run_phase(32'h00000000, TOL_RESET, 7'd3, 30);
    run_phase(32'hFFFFFFFF, 32'h7F800000, 7'd127, 30);
    run_phase(32'h5F3759DF, 32'h3A83126F, 7'd20, 40);
    foreach (corner[i]) operand_q.push_back(corner[i]);
    run_phase(MAGIC_RESET, TOL_RESET, LIMIT_RESET, 80);
    drain();
    repeat (100) @(posedge clk);
    if (expected_q.size() != 0) mismatches++;
    $display("covered %0d operands, %0d results, %0d config writes, %0d runs to the limit",
             ops_sent, results_seen, cfg_writes, limit_runs);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/frsqrt_pkg.sv
sv/frsqrt_ctrl.sv
sv/frsqrt_dp.sv
sv/fast_rsqrt_newton_convergence_unit.sv
sim/tb_fast_rsqrt_newton_convergence_unit.sv
